@@ sv/lltile_pkg.sv @@
// Shared types and codes for the Life-like automaton tile.
// Used by the cell evaluator and the top-level sequencer; depends on nothing.
`default_nettype none
package lltile_pkg;

    localparam int MASK_W = 9;

    // Action selector codes.
    localparam logic [1:0] KIND_WRITE_CELL = 2'd0;
    localparam logic [1:0] KIND_READ_CELL  = 2'd1;
    localparam logic [1:0] KIND_WRITE_HALO = 2'd2;
    localparam logic [1:0] KIND_GENERATION = 2'd3;

    // Sleep mode codes.
    localparam logic [1:0] MODE_ASLEEP = 2'd0;
    localparam logic [1:0] MODE_BORDER = 2'd1;
    localparam logic [1:0] MODE_AWAKE  = 2'd2;

    // Configuration register indexes.
    localparam logic REG_BIRTH   = 1'b0;
    localparam logic REG_SURVIVE = 1'b1;

    // Verdict of the cell evaluator for one cell.
    typedef struct packed {
        logic alive_next;
        logic born;
        logic died;
    } t_eval;

endpackage
`default_nettype wire

@@ sv/lltile_cell_eval.sv @@
// Shared neighbour-count and rule unit, evaluating one cell per cycle.
// Depends on lltile_pkg for the result struct and mask width.
`default_nettype none
module lltile_cell_eval
    import lltile_pkg::*;
(
    input  wire logic [2:0]        i_up,
    input  wire logic [2:0]        i_mid,
    input  wire logic [2:0]        i_dn,
    input  wire logic              i_enable,
    input  wire logic [MASK_W-1:0] i_birth_mask,
    input  wire logic [MASK_W-1:0] i_survive_mask,
    output t_eval                  o_eval
);

    logic [3:0] count;
    logic       center;

    // Sum of the eight neighbours around the center bit.
    assign count = 4'(i_up[0]) + 4'(i_up[1]) + 4'(i_up[2]) + 4'(i_mid[0]) +
                   4'(i_mid[2]) + 4'(i_dn[0]) + 4'(i_dn[1]) + 4'(i_dn[2]);
    assign center = i_mid[1];

    // Apply the birth or survival rule when the cell is evaluated.
    always_comb begin
        o_eval.alive_next = center;
        o_eval.born       = 1'b0;
        o_eval.died       = 1'b0;
        if (i_enable) begin
            if (center) begin
                if (!i_survive_mask[count]) begin
                    o_eval.alive_next = 1'b0;
                    o_eval.died       = 1'b1;
                end
            end else if (i_birth_mask[count]) begin
                o_eval.alive_next = 1'b1;
                o_eval.born       = 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/lltile_row_mem.sv @@
// Row-wide cell store: one write port and one registered read port.
// Rows never written read as all dead through per-row valid bits; no dependencies.
`default_nettype none
module lltile_row_mem #(
    parameter int ROWS  = 16,
    parameter int WIDTH = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_wr_en,
    input  wire logic [$clog2(ROWS)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]        i_wr_data,
    input  wire logic                    i_rd_en,
    input  wire logic [$clog2(ROWS)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]        o_rd_data
);

    logic [WIDTH-1:0] r_mem [ROWS];
    logic [ROWS-1:0]  r_valid;

    // Storage array write.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Valid bits, cleared all at once by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // Registered read; an unwritten row reads as zero.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_valid[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

endmodule
`default_nettype wire

@@ sv/life_like_automaton_tile_step.sv @@
// Top level of the Life-like automaton tile: sequencer, halo ring and counters.
// Depends on lltile_pkg, lltile_cell_eval and lltile_row_mem.
`default_nettype none
// One stream transfer in gives one result transfer out. A halo write goes
// straight to the result state, a cell read or write through the cell state,
// a generation while asleep through the finish state alone, and any other
// generation loads two rows, then scans: the single cell evaluator visits one
// cell per cycle while rows stream through a three-row window from the row
// memory. The next transfer is taken once the result register is empty and
// the sequencer is idle. The tile comes out of reset all dead, no clearing pass.
module life_like_automaton_tile_step
    import lltile_pkg::*;
#(
    parameter int GRID_SIDE = 16,
    parameter int IDLE_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // APB-style configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // col[3:0], row[7:4], value[8], halo_index[15:9],
    // neighbour_border_changed[16], neighbours_all_empty[17], zero pad
    input  wire logic [23:0] s_axis_tdata,
    // kind[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // read_alive[0], births[9:1], deaths[18:10], alive_count[27:19],
    // border_changed[28], sleep_mode[30:29], idle_generations[46:31], zero pad
    output logic      [47:0] m_axis_tdata
);

    localparam int N  = GRID_SIDE;
    localparam int XW = $clog2(N);
    localparam int WW = N + 2;
    localparam int CW = $clog2(N * N + 1);
    localparam int HTOP = 0;
    localparam int HBOT = N + 2;
    localparam int HLEFT = 2 * N + 4;
    localparam int HRIGHT = 3 * N + 4;
    localparam logic [IDLE_BITS-1:0] IDLE_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE, S_CELL_RW, S_LD0, S_LD1, S_SCAN, S_FINISH, S_RESP
    } t_state;

    t_state              r_state;
    logic [1:0]          r_kind;
    logic [XW-1:0]       r_col, r_row;
    logic                r_value, r_nbc, r_nae;
    logic [MASK_W-1:0]   r_birth_mask, r_survive_mask;
    logic [WW-1:0]       r_top, r_bot;
    logic [N-1:0]        r_left, r_right;
    logic [CW-1:0]       r_pop, r_birth_tot, r_death_tot, r_born, r_died;
    logic [1:0]          r_mode;
    logic [IDLE_BITS-1:0] r_idle;
    logic                r_edge_flag, r_edge_acc, r_read_val;
    logic [XW-1:0]       r_x, r_y;
    logic [WW-1:0]       r_up, r_mid, r_dn;
    logic [N-1:0]        r_new_row;
    logic                r_m_valid;
    logic [47:0]         r_m_data;

    logic          accept, cfg_write;
    logic [1:0]    in_kind;
    logic [XW-1:0] in_col, in_row;
    logic [6:0]    in_hidx;
    logic          rd_en, wr_en;
    logic [XW-1:0] rd_addr, wr_addr;
    logic [N-1:0]  wr_data, rd_data, row_now;
    logic [XW:0]   y2;
    logic [XW-1:0] y2_idx;
    logic          is_edge;
    t_eval         ev;
    logic          changed;
    logic [CW-1:0] n_pop;
    logic [1:0]    n_mode;

    // Reduce a four-bit coordinate modulo the tile side.
    function automatic logic [XW-1:0] mod_side(input logic [3:0] v);
        int t;
        t = int'(v);
        for (int k = 0; k < 5; k++) begin
            if (t >= N) begin
                t = t - N;
            end
        end
        return XW'(t);
    endfunction

    // Window row: left halo bit lowest, then the cells, then the right halo bit.
    function automatic logic [WW-1:0] form_row(input logic [N-1:0] bits,
                                               input logic lb, input logic rb);
        return {rb, bits, lb};
    endfunction

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign in_kind   = s_axis_tuser;
    assign in_col    = mod_side(s_axis_tdata[3:0]);
    assign in_row    = mod_side(s_axis_tdata[7:4]);
    assign in_hidx   = s_axis_tdata[15:9];

    assign s_axis_tready = (r_state == S_IDLE) && !r_m_valid;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign pready        = 1'b1;
    assign prdata = 32'(paddr[2] == REG_SURVIVE ? r_survive_mask : r_birth_mask);

    assign y2     = {1'b0, r_y} + (XW+1)'(2);
    assign y2_idx = y2[XW-1:0];
    assign is_edge = (r_x == '0) || (r_x == XW'(N - 1)) ||
                     (r_y == '0) || (r_y == XW'(N - 1));

    lltile_row_mem #(.ROWS(N), .WIDTH(N)) u_rows (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lltile_cell_eval u_eval (
        .i_up           (r_up[r_x +: 3]),
        .i_mid          (r_mid[r_x +: 3]),
        .i_dn           (r_dn[r_x +: 3]),
        .i_enable       ((r_mode == MODE_AWAKE) || is_edge),
        .i_birth_mask   (r_birth_mask),
        .i_survive_mask (r_survive_mask),
        .o_eval         (ev)
    );

    // New row so far, including the cell evaluated this cycle.
    always_comb begin
        row_now      = r_new_row;
        row_now[r_x] = ev.alive_next;
    end

    // Row memory control.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = in_row;
        wr_en   = 1'b0;
        wr_addr = r_y;
        wr_data = row_now;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (in_kind == KIND_WRITE_CELL || in_kind == KIND_READ_CELL)) begin
                    rd_en = 1'b1;
                end else if (accept && in_kind == KIND_GENERATION &&
                             r_mode != MODE_ASLEEP) begin
                    rd_en   = 1'b1;
                    rd_addr = '0;
                end
            end
            S_LD0: begin
                rd_en   = 1'b1;
                rd_addr = XW'(1);
            end
            S_SCAN: begin
                if (r_x == '0 && y2 < (XW+1)'(N)) begin
                    rd_en   = 1'b1;
                    rd_addr = y2_idx;
                end
                wr_en = (r_x == XW'(N - 1));
            end
            S_CELL_RW: begin
                wr_en          = (r_kind == KIND_WRITE_CELL);
                wr_addr        = r_row;
                wr_data        = rd_data;
                wr_data[r_col] = r_value;
            end
            default: begin
            end
        endcase
    end

    // End-of-generation bookkeeping.
    always_comb begin
        changed = (r_born != '0) || (r_died != '0);
        n_pop   = changed ? (r_pop + r_born - r_died) : r_pop;
        if (changed) begin
            n_mode = MODE_AWAKE;
        end else begin
            n_mode = r_nbc ? MODE_BORDER : MODE_ASLEEP;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_birth_mask   <= MASK_W'(8);
            r_survive_mask <= MASK_W'(12);
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_BIRTH:   r_birth_mask   <= pwdata[MASK_W-1:0];
                REG_SURVIVE: r_survive_mask <= pwdata[MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Halo ring, written one bit per transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top   <= '0;
            r_bot   <= '0;
            r_left  <= '0;
            r_right <= '0;
        end else if (accept && in_kind == KIND_WRITE_HALO) begin
            for (int i = 0; i < WW; i++) begin
                if (int'(in_hidx) == HTOP + i) r_top[i] <= s_axis_tdata[8];
                if (int'(in_hidx) == HBOT + i) r_bot[i] <= s_axis_tdata[8];
            end
            for (int i = 0; i < N; i++) begin
                if (int'(in_hidx) == HLEFT + i)  r_left[i]  <= s_axis_tdata[8];
                if (int'(in_hidx) == HRIGHT + i) r_right[i] <= s_axis_tdata[8];
            end
        end
    end

    // Sequencer with tile state and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pop       <= '0;
            r_mode      <= MODE_ASLEEP;
            r_idle      <= '0;
            r_edge_flag <= 1'b0;
            r_birth_tot <= '0;
            r_death_tot <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_kind     <= in_kind;
                        r_col      <= in_col;
                        r_row      <= in_row;
                        r_value    <= s_axis_tdata[8];
                        r_nbc      <= s_axis_tdata[16];
                        r_nae      <= s_axis_tdata[17];
                        r_read_val <= 1'b0;
                        r_born     <= '0;
                        r_died     <= '0;
                        r_edge_acc <= 1'b0;
                        r_up       <= r_top;
                        r_x        <= '0;
                        r_y        <= '0;
                        unique case (in_kind)
                            KIND_WRITE_CELL, KIND_READ_CELL: r_state <= S_CELL_RW;
                            KIND_WRITE_HALO:                 r_state <= S_RESP;
                            KIND_GENERATION: begin
                                r_state <= (r_mode == MODE_ASLEEP) ? S_FINISH : S_LD0;
                            end
                            default: r_state <= S_RESP;
                        endcase
                    end
                end
                S_CELL_RW: begin
                    if (r_kind == KIND_READ_CELL) begin
                        r_read_val <= rd_data[r_col];
                    end else if (rd_data[r_col] != r_value) begin
                        r_pop  <= r_value ? r_pop + CW'(1) : r_pop - CW'(1);
                        r_mode <= MODE_AWAKE;
                    end
                    r_state <= S_RESP;
                end
                S_LD0: begin
                    r_mid   <= form_row(rd_data, r_left[0], r_right[0]);
                    r_state <= S_LD1;
                end
                S_LD1: begin
                    r_dn    <= form_row(rd_data, r_left[1], r_right[1]);
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_new_row[r_x] <= ev.alive_next;
                    if (ev.born) r_born <= r_born + CW'(1);
                    if (ev.died) r_died <= r_died + CW'(1);
                    if ((ev.born || ev.died) && is_edge) r_edge_acc <= 1'b1;
                    if (r_x == XW'(N - 1)) begin
                        // Slide the window down one row.
                        r_x   <= '0;
                        r_up  <= r_mid;
                        r_mid <= r_dn;
                        if (y2 < (XW+1)'(N)) begin
                            r_dn <= form_row(rd_data, r_left[y2_idx], r_right[y2_idx]);
                        end else if (y2 == (XW+1)'(N)) begin
                            r_dn <= r_bot;
                        end
                        if (r_y == XW'(N - 1)) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_y <= r_y + XW'(1);
                        end
                    end else begin
                        r_x <= r_x + XW'(1);
                    end
                end
                S_FINISH: begin
                    r_birth_tot <= r_born;
                    r_death_tot <= r_died;
                    r_edge_flag <= r_edge_acc;
                    r_pop       <= n_pop;
                    r_mode      <= n_mode;
                    if (n_mode == MODE_ASLEEP && n_pop == '0 && r_nae) begin
                        if (r_idle != IDLE_MAX) r_idle <= r_idle + IDLE_BITS'(1);
                    end else begin
                        r_idle <= '0;
                    end
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    r_m_data  <= {1'b0, 16'(r_idle), r_mode, r_edge_flag,
                                  9'(r_pop), 9'(r_death_tot), 9'(r_birth_tot),
                                  r_read_val};
                    r_m_valid <= 1'b1;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ sim/lltile_checker.sv @@
// Checker for the Life-like automaton tile: watches the configuration port and both
// streams, predicts each result from its own copy of the tile state and compares.
// Depends on lltile_pkg.
module lltile_checker
    import lltile_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,
    input  wire logic [1:0]  s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [47:0] m_axis_tdata,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_result_count
);

    localparam int SIDE = 16;
    localparam int HALO_N = 4 * SIDE + 4;

    typedef struct packed {
        logic [15:0] idle_gens;
        logic [1:0]  mode;
        logic        edge_chg;
        logic [8:0]  alive;
        logic [8:0]  deaths;
        logic [8:0]  births;
        logic        read_alive;
    } t_tile_result;

    logic [8:0]  birth_rule, survive_rule;
    logic        grid [SIDE*SIDE];
    logic        halo [HALO_N];
    logic [8:0]  pop, born_last, died_last;
    logic [1:0]  mode;
    logic [15:0] idle_gens;
    logic        edge_last;
    t_tile_result expected_results [$];

    assign o_pending = expected_results.size();

    // Cell state at x, y in -1..SIDE, falling back on the halo ring off the tile.
    function automatic logic cell_at(int x, int y);
        if (y < 0) return halo[x + 1];
        if (y >= SIDE) return halo[SIDE + 2 + x + 1];
        if (x < 0) return halo[2 * (SIDE + 2) + y];
        if (x >= SIDE) return halo[2 * (SIDE + 2) + SIDE + y];
        return grid[y * SIDE + x];
    endfunction

    task automatic run_generation(logic nb_changed, logic nb_empty);
        logic nxt [SIDE*SIDE];
        int born, died, n;
        logic edge_cell, echg;
        born = 0; died = 0; echg = 0;
        nxt = grid;
        if (mode != MODE_ASLEEP) begin
            for (int y = 0; y < SIDE; y++) begin
                for (int x = 0; x < SIDE; x++) begin
                    edge_cell = (x == 0 || x == SIDE - 1 || y == 0 || y == SIDE - 1);
                    if (!edge_cell && mode == MODE_BORDER) continue;
                    n = 0;
                    for (int dy = -1; dy <= 1; dy++)
                        for (int dx = -1; dx <= 1; dx++)
                            if (dx != 0 || dy != 0) n += cell_at(x + dx, y + dy);
                    if (grid[y * SIDE + x]) begin
                        if (!survive_rule[n]) begin
                            nxt[y * SIDE + x] = 0; died++; echg |= edge_cell;
                        end
                    end else if (birth_rule[n]) begin
                        nxt[y * SIDE + x] = 1; born++; echg |= edge_cell;
                    end
                end
            end
        end
        edge_last = echg;
        born_last = 9'(born);
        died_last = 9'(died);
        if (born > 0 || died > 0) begin
            grid = nxt;
            pop = 9'(pop + born - died);
            mode = MODE_AWAKE;
        end else begin
            mode = nb_changed ? MODE_BORDER : MODE_ASLEEP;
        end
        if (mode == MODE_ASLEEP && pop == 0 && nb_empty) begin
            if (idle_gens != 16'hFFFF) idle_gens++;
        end else begin
            idle_gens = 0;
        end
    endtask

    task automatic predict_tile_step(logic [1:0] kind, logic [23:0] d);
        t_tile_result r;
        int ci;
        ci = d[7:4] * SIDE + d[3:0];
        r = '0;
        case (kind)
            KIND_WRITE_CELL: begin
                if (grid[ci] != d[8]) begin
                    pop = d[8] ? pop + 9'd1 : pop - 9'd1;
                    mode = MODE_AWAKE;
                end
                grid[ci] = d[8];
            end
            KIND_READ_CELL: r.read_alive = grid[ci];
            KIND_WRITE_HALO: if (d[15:9] < HALO_N) halo[d[15:9]] = d[8];
            default: run_generation(d[16], d[17]);
        endcase
        r.births = born_last;
        r.deaths = died_last;
        r.alive = pop;
        r.edge_chg = edge_last;
        r.mode = mode;
        r.idle_gens = idle_gens;
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 o_result_count, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_result_count = 0;
    end

    always @(posedge i_clk) begin
        t_tile_result got, want;
        if (!i_rst_n) begin
            birth_rule <= 9'd8;
            survive_rule <= 9'd12;
            for (int i = 0; i < SIDE * SIDE; i++) grid[i] = 0;
            for (int i = 0; i < HALO_N; i++) halo[i] = 0;
            pop = 0; born_last = 0; died_last = 0;
            mode = MODE_ASLEEP; idle_gens = 0; edge_last = 0;
            expected_results.delete();
        end else begin
            // Register writes on the access phase.
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_SURVIVE) survive_rule <= pwdata[8:0];
                else birth_rule <= pwdata[8:0];
            end
            // Results are checked before the accepted input is predicted.
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[46:0];
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result transfer", 1, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.read_alive != want.read_alive)
                        report_mismatch("read_alive", got.read_alive, want.read_alive);
                    if (got.births != want.births)
                        report_mismatch("births", got.births, want.births);
                    if (got.deaths != want.deaths)
                        report_mismatch("deaths", got.deaths, want.deaths);
                    if (got.alive != want.alive)
                        report_mismatch("alive_count", got.alive, want.alive);
                    if (got.edge_chg != want.edge_chg)
                        report_mismatch("border_changed", got.edge_chg, want.edge_chg);
                    if (got.mode != want.mode)
                        report_mismatch("sleep_mode", got.mode, want.mode);
                    if (got.idle_gens != want.idle_gens)
                        report_mismatch("idle_generations", got.idle_gens, want.idle_gens);
                end
                o_result_count++;
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_tile_step(s_axis_tuser, s_axis_tdata);
        end
    end

endmodule

@@ sim/tb_life_like_automaton_tile_step.sv @@
// Testbench top for the Life-like automaton tile: clock, reset, register writes and
// stream stimulus with random idling. Depends on lltile_pkg, lltile_checker and the RTL.
module tb_life_like_automaton_tile_step;
    import lltile_pkg::*;

    logic        i_clk, i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        s_axis_tvalid, s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid, m_axis_tready;
    logic [47:0] m_axis_tdata;
    int          fail_count, pending, result_count;
    int          send_idle_pct, recv_idle_pct;
    int          generation_count;

    life_like_automaton_tile_step dut (.*);

    lltile_checker checker_inst (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // Receiver readiness, stalling at the current rate.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // One input transfer; valid drops afterwards, while the block is busy.
    task automatic send_item(logic [1:0] kind, logic [3:0] col, logic [3:0] row,
                             logic value, logic [6:0] hidx, logic nbc, logic nbe);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        s_axis_tvalid <= 1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {6'd0, nbe, nbc, hidx, value, row, col};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        if (kind == KIND_GENERATION) generation_count++;
    endtask

    task automatic drain;
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(logic reg_idx, logic [8:0] val);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {reg_idx, 2'b00}; pwdata <= 32'(val);
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge i_clk);
    endtask

    task automatic random_item;
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            send_item(KIND_WRITE_CELL, 4'($urandom), 4'($urandom), 1'($urandom), 0, 0, 0);
        else if (pick < 55)
            send_item(KIND_READ_CELL, 4'($urandom), 4'($urandom), 0, 7'($urandom), 0, 0);
        else if (pick < 75)
            send_item(KIND_WRITE_HALO, 0, 0, 1'($urandom),
                      ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(67)),
                      0, 0);
        else
            send_item(KIND_GENERATION, 4'($urandom), 4'($urandom), 1'($urandom),
                      7'($urandom), 1'($urandom), 1'($urandom));
    endtask

    initial begin
        i_rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0;
        m_axis_tready = 0;
        send_idle_pct = 0; recv_idle_pct = 0;
        generation_count = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: idle counting, a three-cell row seed, halo effects, extremes.
        send_item(KIND_GENERATION, 0, 0, 0, 0, 0, 1);
        send_item(KIND_GENERATION, 0, 0, 0, 0, 1, 1);
        send_item(KIND_GENERATION, 0, 0, 0, 0, 0, 0);
        send_item(KIND_WRITE_CELL, 15, 15, 1, 0, 0, 0);
        send_item(KIND_WRITE_CELL, 15, 15, 1, 0, 0, 0);
        send_item(KIND_WRITE_CELL, 0, 0, 1, 0, 0, 0);
        send_item(KIND_WRITE_CELL, 1, 0, 1, 0, 0, 0);
        send_item(KIND_WRITE_CELL, 2, 0, 1, 0, 0, 0);
        send_item(KIND_READ_CELL, 1, 0, 0, 0, 0, 0);
        send_item(KIND_READ_CELL, 5, 5, 0, 0, 0, 0);
        send_item(KIND_WRITE_HALO, 0, 0, 1, 0, 0, 0);
        send_item(KIND_WRITE_HALO, 0, 0, 1, 67, 0, 0);
        send_item(KIND_WRITE_HALO, 0, 0, 1, 68, 0, 0);
        send_item(KIND_WRITE_HALO, 0, 0, 1, 127, 0, 0);
        send_item(KIND_WRITE_HALO, 0, 0, 1, 36, 0, 0);
        send_item(KIND_GENERATION, 15, 15, 1, 127, 1, 1);
        send_item(KIND_GENERATION, 0, 0, 0, 0, 1, 0);
        send_item(KIND_GENERATION, 0, 0, 0, 0, 0, 1);
        send_item(KIND_WRITE_CELL, 15, 15, 0, 0, 0, 0);
        send_item(KIND_GENERATION, 0, 0, 0, 0, 0, 1);
        drain();

        // Random phases across rule settings, extremes included.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin write_reg(REG_BIRTH, 9'h1FF); write_reg(REG_SURVIVE, 9'h000); end
                1: begin write_reg(REG_BIRTH, 9'h000); write_reg(REG_SURVIVE, 9'h1FF); end
                2: begin write_reg(REG_BIRTH, 9'd8);   write_reg(REG_SURVIVE, 9'd12);  end
                3: begin write_reg(REG_BIRTH, 9'h1FE); write_reg(REG_SURVIVE, 9'h101); end
                default: begin
                    write_reg(REG_BIRTH, 9'($urandom));
                    write_reg(REG_SURVIVE, 9'($urandom));
                end
            endcase
            for (int i = 0; i < 272; i++) begin
                if (i < 90) begin send_idle_pct = 19; recv_idle_pct = 74; end
                else if (i < 180) begin send_idle_pct = 74; recv_idle_pct = 19; end
                else begin send_idle_pct = 0; recv_idle_pct = 0; end
                if (i == 135) while (pending != 0) @(posedge i_clk);
                random_item();
            end
            send_idle_pct = 0; recv_idle_pct = 0;
            drain();
        end

        $display("covered %0d results, %0d generations, six rule settings",
                 result_count, generation_count);
        if (fail_count == 0)
            $display("life_like_automaton_tile_step regression: pass");
        else
            $display("life_like_automaton_tile_step regression: fail");
        $finish;
    end

    initial begin
        #40000000;
        $display("life_like_automaton_tile_step regression: fail");
        $finish;
    end

endmodule
